@@ src/hse_pkg.sv @@
// Package: word types, opcodes and fixed widths for the Huffman symbol encoder.
package hse_pkg;

    localparam int SYM_W        = 8;
    localparam int NUM_SYMBOLS  = 256;
    localparam int CODE_FIELD_W = 48;
    localparam int LEN_W        = 6;
    localparam int OP_W         = 2;
    localparam int BYTE_W       = 8;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [SYM_W-1:0]        symbol;
        logic [CODE_FIELD_W-1:0] code_value;
        logic [LEN_W-1:0]        code_length;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_word;

endpackage

@@ src/huffman_symbol_encoder.sv @@
// Top level: Huffman code table, symbol lookup and MSB-first byte packer.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------------
//  input   | in        | i_valid / o_stall  | i_word: operation, symbol, code, length
//  output  | out       | o_valid / i_stall  | o_word: out_byte, last
//
// Cycles: a word is taken every cycle while each item yields at most one byte and
//   i_stall is low; an item of k bytes (k <= (code width + 7) / 8) holds the output
//   until all k drain. Bytes pass the registered table read, then the output register.
// Reset clears the per-symbol written flags, so unwritten lengths read as zero,
//   plus the pending byte and both stages; no clearing pass is needed.
// o_stall rises only when the lookup stage has bytes and the output is busy.
module huffman_symbol_encoder #(
    parameter int MAX_CODE_LEN = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hse_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_stall,
    output hse_pkg::t_out_word o_word
);

    // Stored code width: the smaller of the length limit and the field width.
    localparam int CODE_W    = (MAX_CODE_LEN < hse_pkg::CODE_FIELD_W) ?
                               MAX_CODE_LEN : hse_pkg::CODE_FIELD_W;
    localparam int LEN_W     = hse_pkg::LEN_W;
    localparam int BYTE_W    = hse_pkg::BYTE_W;
    localparam int ENT_W     = CODE_W + LEN_W;
    localparam int ACC_W     = CODE_W + BYTE_W;
    localparam int MAX_BYTES = (CODE_W + BYTE_W - 1) / BYTE_W + 1;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int TOT_W     = LEN_W + 1;

    // ---------------- accept / table access ----------------
    logic in_acc;
    logic is_load;
    logic is_encode;
    logic is_flush;
    logic [LEN_W-1:0] len_sat;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;

    assign in_acc = i_valid && !o_stall;

    always_comb begin
        is_load   = 1'b0;
        is_encode = 1'b0;
        is_flush  = 1'b0;
        case (i_word.operation)
            hse_pkg::OP_LOAD:   is_load   = 1'b1;
            hse_pkg::OP_ENCODE: is_encode = 1'b1;
            hse_pkg::OP_FLUSH:  is_flush  = 1'b1;
            default: ;  // unused opcode: dropped
        endcase
    end

    // Long lengths saturate to the stored code width.
    assign len_sat   = (i_word.code_length > LEN_W'(CODE_W)) ?
                       LEN_W'(CODE_W) : i_word.code_length;
    assign ram_wdata = {len_sat, i_word.code_value[CODE_W-1:0]};

    // One RAM (code + length per symbol). Loads write at accept and encodes
    // read at accept, so a later encode always sees an earlier load.
    hse_ram #(
        .WIDTH (ENT_W),
        .DEPTH (hse_pkg::NUM_SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_load),
        .i_waddr (i_word.symbol),
        .i_wdata (ram_wdata),
        .i_re    (in_acc && is_encode),
        .i_raddr (i_word.symbol),
        .o_rdata (ram_rdata)
    );

    // Per-symbol written flags stand in for the all-zero length reset.
    logic [hse_pkg::NUM_SYMBOLS-1:0] r_len_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
        end else if (in_acc && is_load) begin
            r_len_vld[i_word.symbol] <= 1'b1;
        end
    end

    // ---------------- lookup / pack stage ----------------
    logic r_a_valid;
    logic r_a_flush;
    logic r_a_lv;
    logic a_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc && (is_encode || is_flush)) begin
            r_a_valid <= 1'b1;
        end else if (a_go) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_flush <= is_flush;
            r_a_lv    <= r_len_vld[i_word.symbol];
        end
    end

    // Pending byte: placed bits sit at the top, unused low bits stay zero.
    logic [BYTE_W-1:0] r_pb;
    logic [2:0]        r_pc;

    logic [LEN_W-1:0]  a_len;
    logic [CODE_W-1:0] a_code;
    logic [TOT_W-1:0]  a_sh;
    logic [CODE_W-1:0] a_code_l;
    logic [ACC_W-1:0]  a_acc_enc;
    logic [TOT_W-1:0]  a_tot;
    logic [CNT_W-1:0]  a_nb_enc;
    logic [ACC_W-1:0]  a_rem;

    logic [ACC_W-1:0]  a_acc;
    logic [CNT_W-1:0]  a_nb;
    logic [BYTE_W-1:0] n_pb;
    logic [2:0]        n_pc;

    assign a_len    = r_a_lv ? ram_rdata[ENT_W-1 -: LEN_W] : '0;
    assign a_code   = ram_rdata[CODE_W-1:0];
    // Left-align the code; bits above the length fall off the top.
    assign a_sh     = TOT_W'(CODE_W) - {1'b0, a_len};
    assign a_code_l = a_code << a_sh;
    assign a_acc_enc = {r_pb, {CODE_W{1'b0}}} | ({a_code_l, {BYTE_W{1'b0}}} >> r_pc);
    assign a_tot    = TOT_W'(a_len) + TOT_W'(r_pc);
    assign a_nb_enc = CNT_W'(a_tot >> 3);
    assign a_rem    = a_acc_enc << {a_nb_enc, 3'b000};

    always_comb begin
        if (r_a_flush) begin
            a_acc = {r_pb, {CODE_W{1'b0}}};
            a_nb  = (r_pc != 3'd0) ? CNT_W'(1) : '0;
            n_pb  = '0;
            n_pc  = 3'd0;
        end else begin
            a_acc = a_acc_enc;
            a_nb  = a_nb_enc;
            n_pb  = a_rem[ACC_W-1 -: BYTE_W];
            n_pc  = a_tot[2:0];
        end
    end

    // ---------------- output register ----------------
    logic [ACC_W-1:0] r_e_acc;
    logic [CNT_W-1:0] r_e_cnt;
    logic out_acc;
    logic e_free;

    assign out_acc = o_valid && !i_stall;
    assign e_free  = (r_e_cnt == '0) || ((r_e_cnt == CNT_W'(1)) && out_acc);
    assign a_go    = r_a_valid && ((a_nb == '0) || e_free);
    assign o_stall = r_a_valid && !a_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb <= '0;
            r_pc <= 3'd0;
        end else if (a_go) begin
            r_pb <= n_pb;
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_cnt <= '0;
        end else if (a_go && (a_nb != '0)) begin
            r_e_cnt <= a_nb;
        end else if (out_acc) begin
            r_e_cnt <= r_e_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go && (a_nb != '0)) begin
            r_e_acc <= a_acc;
        end else if (out_acc) begin
            r_e_acc <= r_e_acc << BYTE_W;
        end
    end

    assign o_valid         = (r_e_cnt != '0);
    assign o_word.out_byte = r_e_acc[ACC_W-1 -: BYTE_W];
    assign o_word.last     = (r_e_cnt == CNT_W'(1));

endmodule

@@ src/hse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/hse_checker.sv @@
// Port-level checks for the Huffman symbol encoder, bound to the top level.
module hse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input hse_pkg::t_out_word i_out_word
);

    // Held output word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_word))
        else $error("output word changed while stalled");

    // A taken byte that is not the last of its item is followed by another.
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall && !i_out_word.last |=> i_out_valid)
        else $error("multi-byte item ended without last");

    // Input backpressure only comes from a busy output register.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && (i_out_stall || !i_out_word.last))
        else $error("input stalled while output could drain");

endmodule

bind huffman_symbol_encoder hse_checker u_hse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_word  (o_word)
);

@@ verif/tb.sv @@
// Testbench for huffman_symbol_encoder: directed, random and backpressure tests.
`timescale 1ns / 1ps

module tb;

    localparam int SYM_W        = hse_pkg::SYM_W;
    localparam int LEN_W        = hse_pkg::LEN_W;
    localparam int BYTE_W       = hse_pkg::BYTE_W;
    localparam int OP_W         = hse_pkg::OP_W;
    localparam int CODE_FIELD_W = hse_pkg::CODE_FIELD_W;
    localparam int NUM_SYMBOLS  = hse_pkg::NUM_SYMBOLS;

    localparam int MAX_CODE_LEN = 48;
    // Loaded lengths saturate to the smaller of the parameter and the code field.
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_FIELD_W) ?
                                  MAX_CODE_LEN : CODE_FIELD_W;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    hse_pkg::t_in_word  i_word;
    logic               o_valid;
    logic               i_stall;
    hse_pkg::t_out_word o_word;

    huffman_symbol_encoder #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_word (i_word),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_word (o_word)
    );

    // Shadow copy of the code table and the byte packer.
    logic [CODE_FIELD_W-1:0] code_tbl [NUM_SYMBOLS];
    logic [LEN_W-1:0]        len_tbl  [NUM_SYMBOLS];
    bit                      written  [NUM_SYMBOLS];
    int                      loaded_syms [$];
    logic [BYTE_W-1:0]       pend_byte;
    int                      pend_count;

    hse_pkg::t_out_word packed_bytes_q [$];

    // Traffic shaping, shared between the test tasks and the two drivers.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;

    int errors;
    int cycle_count;
    int n_loads, n_encodes, n_flushes, n_ignored, n_bytes, in_stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Predict the bytes one accepted word produces and queue them in order.
    function automatic void pack_code_bits(input hse_pkg::t_in_word w);
        logic [LEN_W-1:0]        len;
        logic [CODE_FIELD_W-1:0] code;
        logic [BYTE_W-1:0]       held;
        bit                      held_valid;
        hse_pkg::t_out_word      r;
        held_valid = 1'b0;
        held       = '0;
        case (w.operation)
            hse_pkg::OP_LOAD: begin
                n_loads++;
                len = w.code_length;
                if (int'(len) > LEN_LIMIT) len = LEN_W'(LEN_LIMIT);
                code_tbl[w.symbol] = w.code_value;
                len_tbl[w.symbol]  = len;
                if (!written[w.symbol]) begin
                    written[w.symbol] = 1'b1;
                    loaded_syms.push_back(int'(w.symbol));
                end
            end
            hse_pkg::OP_ENCODE: begin
                n_encodes++;
                len  = len_tbl[w.symbol];
                code = code_tbl[w.symbol];
                // Bits go MSB first; a byte is held back one step so the
                // final one of this word can carry last.
                for (int i = int'(len); i > 0; i--) begin
                    if (code[i-1]) pend_byte[7-pend_count] = 1'b1;
                    pend_count++;
                    if (pend_count == 8) begin
                        if (held_valid) begin
                            r.out_byte = held;
                            r.last     = 1'b0;
                            packed_bytes_q.push_back(r);
                        end
                        held       = pend_byte;
                        held_valid = 1'b1;
                        pend_byte  = '0;
                        pend_count = 0;
                    end
                end
                if (held_valid) begin
                    r.out_byte = held;
                    r.last     = 1'b1;
                    packed_bytes_q.push_back(r);
                end
            end
            hse_pkg::OP_FLUSH: begin
                n_flushes++;
                if (pend_count != 0) begin
                    r.out_byte = pend_byte;
                    r.last     = 1'b1;
                    packed_bytes_q.push_back(r);
                    pend_byte  = '0;
                    pend_count = 0;
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
    endfunction

    function automatic hse_pkg::t_in_word mk_word(input logic [OP_W-1:0] op,
                                                  input logic [SYM_W-1:0] sym,
                                                  input logic [CODE_FIELD_W-1:0] code,
                                                  input logic [LEN_W-1:0] len);
        hse_pkg::t_in_word w;
        w.operation   = op;
        w.symbol      = sym;
        w.code_value  = code;
        w.code_length = len;
        return w;
    endfunction

    // Offer one word, hold it until taken, then idle at random.
    // Called right after a rising edge; valid stays high when no gap follows.
    task automatic send_word(input hse_pkg::t_in_word w);
        logic stalled;
        int   gap;
        i_valid <= 1'b1;
        i_word  <= w;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            if (stalled) in_stall_cycles++;
            @(posedge i_clk);
        end while (stalled);
        pack_code_bits(w);
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: random stall, or a long counted hold-off when one is requested.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Output monitor: sample mid-cycle, compare at the edge that takes the word.
    initial begin : byte_checker
        hse_pkg::t_out_word seen;
        hse_pkg::t_out_word want;
        logic               seen_take;
        forever begin
            @(negedge i_clk);
            seen_take = i_rst_n && o_valid && !i_stall;
            seen      = o_word;
            @(posedge i_clk);
            if (seen_take) begin
                n_bytes++;
                if (packed_bytes_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                             $time, seen.out_byte, seen.last);
                end else begin
                    want = packed_bytes_q.pop_front();
                    if (seen.out_byte !== want.out_byte) begin
                        errors++;
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.out_byte, seen.out_byte);
                    end
                    if (seen.last !== want.last) begin
                        errors++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, seen.last);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d bytes still due",
                 $time, cycle_count, packed_bytes_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // Every operation, field extremes, saturation, stray bits, zero length,
    // sub-byte encodes, empty and partial flushes, six-byte encodes, op 3.
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(mk_word(hse_pkg::OP_FLUSH, 8'h00, '0, '0));         // nothing pending
        send_word(mk_word(hse_pkg::OP_LOAD, 8'h00, 48'hFFFF_FFFF_FFF5, 6'd3)); // stray bits
        send_word(mk_word(hse_pkg::OP_LOAD, 8'hFF, '1, 6'd63));       // saturates to 48
        send_word(mk_word(hse_pkg::OP_LOAD, 8'h5A, 48'hA5A5_5A5A_C3C3, 6'd48));
        send_word(mk_word(hse_pkg::OP_LOAD, 8'h81, 48'h1234_5678_9ABC, 6'd0));
        send_word(mk_word(hse_pkg::OP_LOAD, 8'h7E, 48'h0000_0000_0055, 6'd7));
        send_word(mk_word(hse_pkg::OP_LOAD, 8'h3C, '0, 6'd8));
        send_word(mk_word(hse_pkg::OP_LOAD, 8'h01, 48'h0000_0000_0001, 6'd49)); // over limit
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'h00, '1, '1));        // 3 bits, no byte
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'h81, '0, '0));        // zero length
        send_word(mk_word(hse_pkg::OP_FLUSH, 8'hFF, '1, '1));         // partial byte
        send_word(mk_word(hse_pkg::OP_FLUSH, 8'h00, '0, '0));
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'hFF, '0, '0));        // six full bytes
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'h3C, '0, '0));        // exactly one byte
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'h7E, '0, '0));        // 7 pending
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'h5A, '0, '0));        // 7 + 48 bits
        send_word(mk_word(hse_pkg::OP_FLUSH, 8'h00, '0, '0));
        send_word(mk_word(OP_UNUSED, 8'hFF, '1, '1));                 // ignored
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'h01, '0, '0));
        send_word(mk_word(hse_pkg::OP_LOAD, 8'h01, 48'h0000_0000_00A7, 6'd8)); // overwrite
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'h01, '0, '0));        // sees new entry
        send_word(mk_word(hse_pkg::OP_FLUSH, 8'h00, '0, '0));
    endtask

    // Mostly table loads and encodes of loaded symbols, with flushes and
    // ignored words mixed in; code lengths lean toward a byte or less.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        hse_pkg::t_in_word w;
        int                done;
        int                pick;
        int                lsel;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_items) begin
            pick          = $urandom_range(99);
            lsel          = $urandom_range(99);
            w.symbol      = SYM_W'($urandom);
            w.code_value  = {16'($urandom), $urandom};
            if (lsel < 65)      w.code_length = LEN_W'($urandom_range(1, 8));
            else if (lsel < 85) w.code_length = LEN_W'($urandom_range(9, 48));
            else if (lsel < 92) w.code_length = '0;
            else                w.code_length = LEN_W'($urandom_range(49, 63));
            if (pick < 14 || loaded_syms.size() == 0) begin
                w.operation = hse_pkg::OP_LOAD;
            end else if (pick < 80) begin
                w.operation = hse_pkg::OP_ENCODE;
                w.symbol    = SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
            end else if (pick < 95) begin
                w.operation = hse_pkg::OP_FLUSH;
            end else begin
                w.operation = OP_UNUSED;
            end
            send_word(w);
            if (w.operation != OP_UNUSED) done++;
        end
    endtask

    // Receiver holds off for a long stretch while six-byte encodes keep
    // coming, so the pipeline fills and the input must stall.
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(mk_word(hse_pkg::OP_LOAD, 8'hC7, 48'h9E37_79B9_7F4A, 6'd48));
        hold_request = 400;
        repeat (12) send_word(mk_word(hse_pkg::OP_ENCODE, 8'hC7, '0, '0));
        send_word(mk_word(hse_pkg::OP_LOAD, 8'h2B, 48'h0000_0000_0005, 6'd5));
        send_word(mk_word(hse_pkg::OP_ENCODE, 8'h2B, '0, '0));
        send_word(mk_word(hse_pkg::OP_FLUSH, 8'h00, '0, '0));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_word       = '0;
        i_stall      = 1'b0;
        hold_request = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        errors = 0;
        n_loads = 0; n_encodes = 0; n_flushes = 0; n_ignored = 0;
        n_bytes = 0; in_stall_cycles = 0;
        pend_byte  = '0;
        pend_count = 0;
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
            code_tbl[s] = '0;
            len_tbl[s]  = '0;
            written[s]  = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(30, 0, 0);
        test_random_traffic(30, 77, 0);
        test_random_traffic(30, 0, 77);
        test_random_traffic(30, 10, 10);
        test_output_holdoff();

        i_valid        <= 1'b0;
        recv_stall_pct = 0;
        while (packed_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d loads, %0d encodes, %0d flushes, %0d ignored words;",
                 n_loads, n_encodes, n_flushes, n_ignored);
        $display("%0d bytes checked over four idle/stall mixes plus a long output hold-off;",
                 n_bytes);
        $display("input stalled %0d cycles.", in_stall_cycles);
        if (errors == 0 && packed_bytes_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d bytes never arrived", errors, packed_bytes_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ huffman_symbol_encoder.f @@
src/hse_pkg.sv
src/hse_ram.sv
src/huffman_symbol_encoder.sv
src/hse_checker.sv
verif/tb.sv
